[design/srfa_pkg.sv]
package srfa_pkg;

  localparam int DEFAULT_ROW_COUNT = 16;

  // Cells per row and the index bits that select a cell within a row.
  localparam int BYTE_ROW_CELLS = 64;
  localparam int WORD_ROW_CELLS = 32;
  localparam int BYTE_IDX_W     = 6;
  localparam int WORD_IDX_W     = 5;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;

  // The divider always works on full words; byte operands are zero-extended.
  localparam int DIV_W = WORD_W;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
  localparam logic [WORD_W-1:0] WORD_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    ACT_BYTE_ADD  = 4'd0,
    ACT_BYTE_SUB  = 4'd1,
    ACT_BYTE_MUL  = 4'd2,
    ACT_BYTE_DIV  = 4'd3,
    ACT_BYTE_MOD  = 4'd4,
    ACT_BYTE_AND  = 4'd5,
    ACT_BYTE_OR   = 4'd6,
    ACT_BYTE_XOR  = 4'd7,
    ACT_WORD_ADD  = 4'd8,
    ACT_WORD_SUB  = 4'd9,
    ACT_WORD_MUL  = 4'd10,
    ACT_WORD_DIV  = 4'd11,
    ACT_WORD_MOD  = 4'd12,
    ACT_LOAD_BYTE = 4'd13,
    ACT_LOAD_WORD = 4'd14
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_DIVIDE,
    S_FINISH
  } state_t;

endpackage

[design/srfa_ram.sv]
module srfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[design/srfa_div.sv]
module srfa_div
  import srfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W-1:0] quo_next;

  // One restoring step per cycle. A zero divisor needs no special case:
  // every trial subtraction succeeds, so the quotient ends as all ones and
  // the remainder as the dividend.
  always_comb begin
    logic [DIV_W:0] shifted;
    logic           fits;
    shifted  = {remainder, quotient[DIV_W-1]};
    fits     = shifted >= {1'b0, dvs};
    rem_next = fits ? DIV_W'(shifted - {1'b0, dvs}) : shifted[DIV_W-1:0];
    quo_next = {quotient[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvs       <= divisor;
      count     <= CNT_W'(DIV_W - 1);
    end else if (busy) begin
      remainder <= rem_next;
      quotient  <= quo_next;
      count     <= count - 1'b1;
    end
  end

endmodule

[design/saturating_register_file_alu.sv]
// Saturating register-file ALU. Each row holds a byte file of 64 cells and a
// word file of 32 cells, kept in two RAMs with a registered read; one item
// reads two cells of a row, combines them and writes the destination cell,
// and its result (the stored value and a divide-by-zero flag) leaves through
// an output register, so the next item is taken while a result waits. After
// reset a clearing pass zeroes both files, with in_stall high. One item is
// worked on at a time: add, subtract, multiply, logic and load go through
// accept with operand read, execute and write back; divide and modulo run
// the 16-step radix-2 divider between execute and write back. A row not
// below ROW_COUNT or action 15 writes nothing and returns zero.
module saturating_register_file_alu
  import srfa_pkg::*;
#(
  parameter int ROW_COUNT = DEFAULT_ROW_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [3:0]  row,
  input  logic [5:0]  first_source,
  input  logic [5:0]  second_source,
  input  logic [5:0]  destination,
  input  logic [15:0] load_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] written_value,
  output logic        divide_by_zero
);

  localparam int BYTE_DEPTH = ROW_COUNT * BYTE_ROW_CELLS;
  localparam int WORD_DEPTH = ROW_COUNT * WORD_ROW_CELLS;
  localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
  localparam int WORD_AW    = $clog2(WORD_DEPTH);
  localparam logic [BYTE_AW-1:0] CLR_LAST = BYTE_AW'(BYTE_DEPTH - 1);

  state_t state, state_next;

  logic               in_xfer;
  logic               finish_fire;
  logic [BYTE_AW-1:0] clr_addr;

  // Item held while it is worked on.
  action_t            op;
  logic               item_ok;
  logic [BYTE_AW-1:0] byte_dst;
  logic [WORD_AW-1:0] word_dst;
  logic [WORD_W-1:0]  lv;
  logic [WORD_W-1:0]  res;
  logic               dz;

  logic [BYTE_AW-1:0] byte_rd_a, byte_rd_b;
  logic [WORD_AW-1:0] word_rd_a, word_rd_b;
  logic [BYTE_W-1:0]  byte_a, byte_b;
  logic [WORD_W-1:0]  word_a, word_b;

  logic               byte_we, word_we;
  logic [BYTE_AW-1:0] byte_wr_addr;
  logic [WORD_AW-1:0] word_wr_addr;
  logic [BYTE_W-1:0]  byte_wr_data;
  logic [WORD_W-1:0]  word_wr_data;

  logic               is_div_op, is_byte_op, is_quotient;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_divisor, div_quo, div_rem;
  logic [WORD_W-1:0]  res_exec, res_div;
  logic               writes_byte, writes_word;

  assign in_xfer     = in_valid && !in_stall;
  assign finish_fire = (state == S_FINISH) && (!out_valid || !out_stall);

  assign byte_rd_a = BYTE_AW'((32'(row) << BYTE_IDX_W) | 32'(first_source));
  assign byte_rd_b = BYTE_AW'((32'(row) << BYTE_IDX_W) | 32'(second_source));
  assign word_rd_a = WORD_AW'((32'(row) << WORD_IDX_W) |
                              32'(first_source[WORD_IDX_W-1:0]));
  assign word_rd_b = WORD_AW'((32'(row) << WORD_IDX_W) |
                              32'(second_source[WORD_IDX_W-1:0]));

  assign is_div_op   = (op == ACT_BYTE_DIV) || (op == ACT_BYTE_MOD) ||
                       (op == ACT_WORD_DIV) || (op == ACT_WORD_MOD);
  assign is_byte_op  = (op == ACT_BYTE_DIV) || (op == ACT_BYTE_MOD);
  assign is_quotient = (op == ACT_BYTE_DIV) || (op == ACT_WORD_DIV);
  assign writes_byte = item_ok && (op <= ACT_BYTE_XOR || op == ACT_LOAD_BYTE);
  assign writes_word = item_ok && ((op >= ACT_WORD_ADD && op <= ACT_WORD_MOD) ||
                                   op == ACT_LOAD_WORD);

  assign div_dividend = is_byte_op ? {8'b0, byte_a} : word_a;
  assign div_divisor  = is_byte_op ? {8'b0, byte_b} : word_b;
  assign res_div      = is_quotient ? div_quo : div_rem;

  srfa_ram #(.WIDTH(BYTE_W), .DEPTH(BYTE_DEPTH)) u_byte_ram (
    .clk       (clk),
    .wr_en     (byte_we),
    .wr_addr   (byte_wr_addr),
    .wr_data   (byte_wr_data),
    .rd_en     (in_xfer),
    .rd_addr_a (byte_rd_a),
    .rd_addr_b (byte_rd_b),
    .rd_data_a (byte_a),
    .rd_data_b (byte_b)
  );

  srfa_ram #(.WIDTH(WORD_W), .DEPTH(WORD_DEPTH)) u_word_ram (
    .clk       (clk),
    .wr_en     (word_we),
    .wr_addr   (word_wr_addr),
    .wr_data   (word_wr_data),
    .rd_en     (in_xfer),
    .rd_addr_a (word_rd_a),
    .rd_addr_b (word_rd_b),
    .rd_data_a (word_a),
    .rd_data_b (word_b)
  );

  srfa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Result of every operation that does not go through the divider.
  always_comb begin
    logic [BYTE_W:0]     bsum;
    logic [2*BYTE_W-1:0] bprod;
    logic [WORD_W:0]     wsum;
    logic [2*WORD_W-1:0] wprod;
    bsum     = {1'b0, byte_a} + {1'b0, byte_b};
    bprod    = {8'b0, byte_a} * {8'b0, byte_b};
    wsum     = {1'b0, word_a} + {1'b0, word_b};
    wprod    = {16'b0, word_a} * {16'b0, word_b};
    res_exec = '0;
    unique case (op)
      ACT_BYTE_ADD: res_exec = {8'b0, bsum[BYTE_W] ? BYTE_MAX : bsum[BYTE_W-1:0]};
      ACT_BYTE_SUB: res_exec = {8'b0, (byte_a >= byte_b) ? byte_a - byte_b : 8'b0};
      ACT_BYTE_MUL: begin
        // Products from 256 up to 32767 saturate; larger ones keep the low byte.
        if (!bprod[15] && bprod[14:8] != '0) begin
          res_exec = {8'b0, BYTE_MAX};
        end else begin
          res_exec = {8'b0, bprod[7:0]};
        end
      end
      ACT_BYTE_AND: res_exec = {8'b0, byte_a & byte_b};
      ACT_BYTE_OR:  res_exec = {8'b0, byte_a | byte_b};
      ACT_BYTE_XOR: res_exec = {8'b0, byte_a ^ byte_b};
      ACT_WORD_ADD: res_exec = wsum[WORD_W] ? WORD_MAX : wsum[WORD_W-1:0];
      ACT_WORD_SUB: res_exec = (word_a >= word_b) ? word_a - word_b : 16'b0;
      ACT_WORD_MUL: begin
        // Products from 2^16 up to below 2^31 saturate; at 2^31 and above the product wraps.
        if (!wprod[31] && wprod[30:16] != '0) begin
          res_exec = WORD_MAX;
        end else begin
          res_exec = wprod[15:0];
        end
      end
      ACT_LOAD_BYTE: res_exec = {8'b0, lv[7:0]};
      ACT_LOAD_WORD: res_exec = lv;
      default:       res_exec = '0;
    endcase
    if (!item_ok) begin
      res_exec = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = (item_ok && is_div_op) ? S_DIVIDE : S_FINISH;
      end
      S_DIVIDE: begin
        if (div_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall     = (state != S_IDLE);
    div_start    = (state == S_EXEC) && item_ok && is_div_op;
    byte_we      = 1'b0;
    word_we      = 1'b0;
    byte_wr_addr = byte_dst;
    word_wr_addr = word_dst;
    byte_wr_data = res[BYTE_W-1:0];
    word_wr_data = res;
    unique case (state)
      S_CLEAR: begin
        byte_we      = 1'b1;
        word_we      = 32'(clr_addr) < WORD_DEPTH;
        byte_wr_addr = clr_addr;
        word_wr_addr = clr_addr[WORD_AW-1:0];
        byte_wr_data = '0;
        word_wr_data = '0;
      end
      S_FINISH: begin
        byte_we = finish_fire && writes_byte;
        word_we = finish_fire && writes_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op       <= action_t'(action);
      item_ok  <= (32'(row) < ROW_COUNT) && (action <= 4'(ACT_LOAD_WORD));
      byte_dst <= BYTE_AW'((32'(row) << BYTE_IDX_W) | 32'(destination));
      word_dst <= WORD_AW'((32'(row) << WORD_IDX_W) |
                           32'(destination[WORD_IDX_W-1:0]));
      lv       <= load_value;
    end
    if (state == S_EXEC) begin
      res <= res_exec;
      dz  <= item_ok && is_div_op && (div_divisor == '0);
    end else if (state == S_DIVIDE && div_done) begin
      res <= is_byte_op ? {8'b0, res_div[BYTE_W-1:0]} : res_div;
    end
    if (finish_fire) begin
      written_value  <= res;
      divide_by_zero <= dz;
    end
  end

endmodule

[design/srfa_checker.sv]
module srfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] written_value,
  input logic        divide_by_zero
);

  logic [2:0] pending;

  // Items taken in whose results have not yet been transferred out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_valid && !in_stall) - 3'(out_valid && !out_stall);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(written_value) &&
                               $stable(divide_by_zero))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result shown with no item outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more than two items outstanding");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not held in clearing pass after reset");

endmodule

bind saturating_register_file_alu srfa_checker u_srfa_checker (.*);

[tb/saturating_register_file_alu_tb.sv]
`timescale 1ns / 1ps

module saturating_register_file_alu_tb;
  import srfa_pkg::*;

  localparam logic [3:0] ACT_UNUSED = 4'd15;
  localparam int ROWS = DEFAULT_ROW_COUNT;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [15:0] value;
    logic        zero_div;
  } alu_result_t;

  // Keeps a copy of both register files and the results still owed by the block.
  class cell_file_scoreboard;
    logic [7:0]  byte_file [ROWS*BYTE_ROW_CELLS];
    logic [15:0] word_file [ROWS*WORD_ROW_CELLS];
    alu_result_t owed_q [$];
    int mismatches;
    int checked;
    int byte_ops;
    int word_ops;
    int loads;
    int zero_divides;

    function new();
      foreach (byte_file[i]) byte_file[i] = '0;
      foreach (word_file[i]) word_file[i] = '0;
    endfunction

    function void note_item(logic [3:0] act, logic [3:0] row, logic [5:0] src_a,
                            logic [5:0] src_b, logic [5:0] dst, logic [15:0] lv);
      int bbase;
      int wbase;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      alu_result_t res;
      bbase = row * BYTE_ROW_CELLS;
      wbase = row * WORD_ROW_CELLS;
      res = '0;
      if (act <= ACT_BYTE_XOR) begin
        a = 32'(byte_file[bbase + src_a]);
        b = 32'(byte_file[bbase + src_b]);
        r = 0;
        case (act)
          ACT_BYTE_ADD: r = (a + b > 32'hFF) ? 32'hFF : a + b;
          ACT_BYTE_SUB: r = (a >= b) ? a - b : 0;
          ACT_BYTE_MUL: begin
            r = a * b;
            // Mid-range products clamp, very large ones wrap to the low byte.
            if (r >= 32'h100 && r <= 32'h7FFF) r = 32'hFF;
          end
          ACT_BYTE_DIV: begin
            res.zero_div = (b == 0);
            r = (b == 0) ? 32'hFF : a / b;
          end
          ACT_BYTE_MOD: begin
            res.zero_div = (b == 0);
            r = (b == 0) ? a : a % b;
          end
          ACT_BYTE_AND: r = a & b;
          ACT_BYTE_OR:  r = a | b;
          default:      r = a ^ b;
        endcase
        byte_file[bbase + dst] = r[7:0];
        res.value = {8'h00, r[7:0]};
        byte_ops++;
      end else if (act <= ACT_WORD_MOD) begin
        a = 32'(word_file[wbase + src_a[4:0]]);
        b = 32'(word_file[wbase + src_b[4:0]]);
        r = 0;
        case (act)
          ACT_WORD_ADD: r = (a + b > 32'hFFFF) ? 32'hFFFF : a + b;
          ACT_WORD_SUB: r = (a >= b) ? a - b : 0;
          ACT_WORD_MUL: begin
            r = a * b;
            // Products that stay positive as 32-bit signed clamp; others wrap.
            if (r > 32'hFFFF && r <= 32'h7FFF_FFFF) r = 32'hFFFF;
          end
          ACT_WORD_DIV: begin
            res.zero_div = (b == 0);
            r = (b == 0) ? 32'hFFFF : a / b;
          end
          default: begin
            res.zero_div = (b == 0);
            r = (b == 0) ? a : a % b;
          end
        endcase
        word_file[wbase + dst[4:0]] = r[15:0];
        res.value = r[15:0];
        word_ops++;
      end else if (act == ACT_LOAD_BYTE) begin
        byte_file[bbase + dst] = lv[7:0];
        res.value = {8'h00, lv[7:0]};
        loads++;
      end else if (act == ACT_LOAD_WORD) begin
        word_file[wbase + dst[4:0]] = lv;
        res.value = lv;
        loads++;
      end
      if (res.zero_div) zero_divides++;
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] value, logic zero_div);
      alu_result_t exp_res;
      checked++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: value %h divide_by_zero %b",
                   $realtime, value, zero_div);
        return;
      end
      exp_res = owed_q.pop_front();
      if (value !== exp_res.value || zero_div !== exp_res.zero_div) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: mismatch: expected value %h divide_by_zero %b, ",
                    "got value %h divide_by_zero %b"},
                   $realtime, exp_res.value, exp_res.zero_div, value, zero_div);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  action = '0;
  logic [3:0]  row = '0;
  logic [5:0]  first_source = '0;
  logic [5:0]  second_source = '0;
  logic [5:0]  destination = '0;
  logic [15:0] load_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] written_value;
  logic        divide_by_zero;

  cell_file_scoreboard cells = new();
  bit in_burst = 1'b0;
  int idle_count = 0;
  int items_sent = 0;

  saturating_register_file_alu u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .row           (row),
    .first_source  (first_source),
    .second_source (second_source),
    .destination   (destination),
    .load_value    (load_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .written_value (written_value),
    .divide_by_zero(divide_by_zero)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Cell indices cluster at both ends of a row so that results feed later operands.
  function automatic logic [5:0] pick_cell();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    if ($urandom_range(0, 1) == 0) return 6'($urandom_range(0, 3));
    return 6'($urandom_range(60, 63));
  endfunction

  task automatic send_item(input logic [3:0] act, input logic [3:0] r, input logic [5:0] sa,
                           input logic [5:0] sb, input logic [5:0] dst, input logic [15:0] lv);
    int gap;
    gap = in_burst ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    row           <= r;
    first_source  <= sa;
    second_source <= sb;
    destination   <= dst;
    load_value    <= lv;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  // Transfer monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        cells.note_item(action, row, first_source, second_source, destination, load_value);
      if (out_valid && !out_stall)
        cells.check_result(written_value, divide_by_zero);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, cells.pending());
        $display("saturating_register_file_alu_tb failed");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // Result-side backpressure: quiet stretches mixed with stalls of random length.
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        hold = idle_cycles();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [3:0]  act;
    logic [15:0] lv;
    int          pick;
    int          directed;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Byte file extremes in row 0: saturation, floor, multiply clamp and wrap,
    // zero divisors, and the logic operations.
    send_item(ACT_LOAD_BYTE, 4'd0, 6'd0, 6'd0, 6'd0, 16'hFFFF);
    send_item(ACT_LOAD_BYTE, 4'd0, 6'd0, 6'd0, 6'd1, 16'hFF01);
    send_item(ACT_BYTE_ADD, 4'd0, 6'd0, 6'd1, 6'd2, 16'h0000);
    send_item(ACT_BYTE_SUB, 4'd0, 6'd1, 6'd0, 6'd3, 16'h0000);
    send_item(ACT_BYTE_MUL, 4'd0, 6'd0, 6'd0, 6'd4, 16'h0000);
    send_item(ACT_LOAD_BYTE, 4'd0, 6'd0, 6'd0, 6'd5, 16'h0010);
    send_item(ACT_BYTE_MUL, 4'd0, 6'd5, 6'd5, 6'd6, 16'h0000);
    send_item(ACT_BYTE_DIV, 4'd0, 6'd0, 6'd63, 6'd7, 16'h0000);
    send_item(ACT_BYTE_MOD, 4'd0, 6'd1, 6'd62, 6'd8, 16'h0000);
    send_item(ACT_BYTE_DIV, 4'd0, 6'd0, 6'd5, 6'd9, 16'h0000);
    send_item(ACT_BYTE_MOD, 4'd0, 6'd0, 6'd5, 6'd10, 16'h0000);
    send_item(ACT_BYTE_AND, 4'd0, 6'd0, 6'd5, 6'd11, 16'h0000);
    send_item(ACT_BYTE_OR, 4'd0, 6'd1, 6'd5, 6'd12, 16'h0000);
    send_item(ACT_BYTE_XOR, 4'd0, 6'd0, 6'd5, 6'd63, 16'h0000);
    // Word file in row 15, with indices above 31 folding onto the cell 32 below them.
    send_item(ACT_LOAD_WORD, 4'd15, 6'd0, 6'd0, 6'd63, 16'hFFFF);
    send_item(ACT_LOAD_WORD, 4'd15, 6'd0, 6'd0, 6'd0, 16'h0001);
    send_item(ACT_WORD_ADD, 4'd15, 6'd31, 6'd32, 6'd1, 16'h0000);
    send_item(ACT_WORD_SUB, 4'd15, 6'd0, 6'd63, 6'd2, 16'h0000);
    send_item(ACT_WORD_MUL, 4'd15, 6'd63, 6'd31, 6'd3, 16'h0000);
    send_item(ACT_LOAD_WORD, 4'd15, 6'd0, 6'd0, 6'd4, 16'h0100);
    send_item(ACT_WORD_MUL, 4'd15, 6'd4, 6'd36, 6'd5, 16'h0000);
    send_item(ACT_WORD_DIV, 4'd15, 6'd63, 6'd6, 6'd7, 16'h0000);
    send_item(ACT_WORD_MOD, 4'd15, 6'd4, 6'd38, 6'd8, 16'h0000);
    send_item(ACT_WORD_DIV, 4'd15, 6'd31, 6'd4, 6'd9, 16'h0000);
    send_item(ACT_WORD_MOD, 4'd15, 6'd31, 6'd4, 6'd10, 16'h0000);
    send_item(ACT_UNUSED, 4'd7, 6'd63, 6'd63, 6'd63, 16'hFFFF);
    directed = items_sent;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      in_burst = (i % 300) < 50;
      pick = $urandom_range(0, 99);
      if (pick < 25) act = ($urandom_range(0, 1) == 0) ? ACT_LOAD_BYTE : ACT_LOAD_WORD;
      else if (pick < 97) act = 4'($urandom_range(0, 12));
      else act = ACT_UNUSED;
      case ($urandom_range(0, 5))
        0:       lv = 16'h0000;
        1:       lv = 16'hFFFF;
        2:       lv = 16'($urandom_range(0, 20));
        3:       lv = 16'($urandom_range(250, 260));
        default: lv = 16'($urandom_range(0, 16'hFFFF));
      endcase
      send_item(act, ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                                : 4'($urandom_range(0, ROWS - 1)),
                pick_cell(), pick_cell(), pick_cell(), lv);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (cells.pending() != 0);
    repeat (30) @(posedge clk);

    $display("Sent %0d items (%0d directed): %0d byte ops, %0d word ops, %0d loads.",
             items_sent, directed, cells.byte_ops, cells.word_ops, cells.loads);
    $display("Checked %0d results, %0d with a zero divisor, %0d mismatches.",
             cells.checked, cells.zero_divides, cells.mismatches);
    if (cells.mismatches == 0 && cells.pending() == 0) begin
      $display("saturating_register_file_alu_tb passed");
    end else begin
      $display("saturating_register_file_alu_tb failed");
    end
    $finish;
  end

endmodule
